// ----- hdl/ars_pkg.sv -----
// ============================================================================
// ars_pkg: shared types and constants for the ADC round-robin scanner
// Request layouts, result layouts, command and register codes.
// ============================================================================
package ars_pkg;

    // Default number of scanned channels (channel 0 is never converted).
    localparam int NUM_CHANNELS_DEF = 9;

    // Channels that have an enable bit in the mask register.
    localparam int MASK_BITS = 9;

    // Width of a channel index and of the scan pointer.
    localparam int PTR_W = 4;

    // Width of one converter sample.
    localparam int SAMPLE_W = 10;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = MASK_BITS;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_ENABLE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MASK = 1'b1;

    // Request command codes.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic                command;
        logic                conversion_done;
        logic [SAMPLE_W-1:0] conversion_value;
        logic [PTR_W-1:0]    read_channel;
    } in_item_t;

    typedef struct packed {
        logic                start_conversion;
        logic [PTR_W-1:0]    mux_channel;
        logic [SAMPLE_W-1:0] read_value;
        logic                read_ok;
    } out_item_t;

    // Outcome of the next-enabled-channel search.
    typedef struct packed {
        logic             found;
        logic [PTR_W-1:0] channel;
    } search_res_t;

endpackage

// ----- hdl/ars_chan_search.sv -----
// ============================================================================
// ars_chan_search: next enabled channel finder
// Priority encoder that returns the lowest enabled channel at or above the
// scan pointer.
// ============================================================================
module ars_chan_search
    import ars_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic [NUM_CHANNELS-1:0] chan_en,
    input  logic [PTR_W-1:0]        start_ptr,
    output search_res_t             res
);

    // Walk downward so the lowest qualifying channel wins. When nothing is
    // found the channel field carries the channel count, modulo the pointer
    // width, which the next tick wraps back to zero.
    always_comb
    begin
        res.found   = 1'b0;
        res.channel = PTR_W'(NUM_CHANNELS);
        for (int i = NUM_CHANNELS - 1; i >= 0; i--)
        begin
            if (chan_en[i] && ((PTR_W + 1)'(i) >= {1'b0, start_ptr}))
            begin
                res.found   = 1'b1;
                res.channel = PTR_W'(i);
            end
        end
    end

endmodule

// ----- hdl/adc_round_robin_scanner.sv -----
// ============================================================================
// adc_round_robin_scanner: round-robin ADC channel scan sequencer
// Steps a scan pointer over the enabled channels, starts conversions, stores
// finished samples per channel and answers sample read requests.
// ============================================================================
//
// Channel   Direction  Handshake            Payload
// --------  ---------  -------------------  ----------------------------------
// in        request    in_valid / in_stall  in_data  (command, done, value, ch)
// out       result     out_valid/out_stall  out_data (start, mux, value, ok)
// cfg       write      cfg_we               cfg_index, cfg_data
//
// Every request produces exactly one result. A request is captured in an
// input register and processed against the scan state once the stage can
// advance. Its result is loaded into the output register, which raises
// out_valid. One request is taken every cycle unless the output stalls; the
// single processing stage updates all scan state in the same cycle it
// produces a result. Reset (rst_n low) clears the valid flags of both
// pipeline registers, the configuration, the pending-conversion flag, the
// pointer and the sample store. A stall on the output holds the result
// register, the input register then holds its request, and in_stall rises.
//
module adc_round_robin_scanner
    import ars_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,

    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Input pipeline register.
    logic     in_valid_reg, in_valid_next;
    in_item_t in_item_reg,  in_item_next;

    // Result register.
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg,  out_item_next;

    // Configuration registers.
    logic                 scan_enable_reg, scan_enable_next;
    logic [MASK_BITS-1:0] chan_mask_reg,   chan_mask_next;

    // Scan state.
    logic                waiting_reg,  waiting_next;
    logic [PTR_W-1:0]    scan_ptr_reg, scan_ptr_next;
    logic [SAMPLE_W-1:0] sample_reg  [NUM_CHANNELS];
    logic [SAMPLE_W-1:0] sample_next [NUM_CHANNELS];

    logic                    advance;
    logic                    accept;
    logic [PTR_W-1:0]        ptr_wrap;
    logic [15:0]             mask_pad;
    logic [15:0]             chan_en16;
    logic [NUM_CHANNELS-1:0] chan_en;
    search_res_t             search;

    // The processing stage moves whenever it holds a request and the result
    // register is empty or being emptied this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // A channel counts as enabled only if it exists, is not channel zero and
    // has a set bit in the mask. Channels past the mask have no enable bit.
    assign mask_pad = {{(16 - MASK_BITS){1'b0}}, chan_mask_reg};

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            chan_en16[i] = (i != 0) && (i < NUM_CHANNELS) && (i < MASK_BITS)
                           && mask_pad[i];
        end
    end

    assign chan_en = chan_en16[NUM_CHANNELS-1:0];

    // The pointer wraps to zero once it has run past the last channel.
    assign ptr_wrap = ({1'b0, scan_ptr_reg} >= (PTR_W + 1)'(NUM_CHANNELS)) ?
                      '0 : scan_ptr_reg;

    ars_chan_search #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_search (
        .chan_en   (chan_en),
        .start_ptr (ptr_wrap),
        .res       (search)
    );

    always_comb
    begin
        in_valid_next    = in_valid_reg;
        in_item_next     = in_item_reg;
        out_valid_next   = out_valid_reg;
        out_item_next    = out_item_reg;
        scan_enable_next = scan_enable_reg;
        chan_mask_next   = chan_mask_reg;
        waiting_next     = waiting_reg;
        scan_ptr_next    = scan_ptr_reg;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            sample_next[i] = sample_reg[i];
        end

        // Input register: load on accept, empty when the stage advances.
        if (accept)
        begin
            in_valid_next = 1'b1;
            in_item_next  = in_data;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (advance)
        begin
            out_item_next = '0;

            case (in_item_reg.command)
                CMD_TICK:
                begin
                    scan_ptr_next = ptr_wrap;
                    if (scan_enable_reg)
                    begin
                        if (!waiting_reg)
                        begin
                            // Idle: look for the next enabled channel and start
                            // a conversion there, or park past the end.
                            scan_ptr_next = search.channel;
                            if (search.found)
                            begin
                                waiting_next                   = 1'b1;
                                out_item_next.start_conversion = 1'b1;
                            end
                        end
                        else if (in_item_reg.conversion_done)
                        begin
                            // Capture the sample even if the channel has been
                            // disabled since the conversion started.
                            for (int i = 0; i < NUM_CHANNELS; i++)
                            begin
                                if (ptr_wrap == PTR_W'(i))
                                begin
                                    sample_next[i] = in_item_reg.conversion_value;
                                end
                            end
                            waiting_next  = 1'b0;
                            scan_ptr_next = ptr_wrap + 1'b1;
                        end
                    end
                end

                CMD_READ:
                begin
                    if (chan_en16[in_item_reg.read_channel])
                    begin
                        out_item_next.read_ok = 1'b1;
                        for (int i = 0; i < NUM_CHANNELS; i++)
                        begin
                            if (in_item_reg.read_channel == PTR_W'(i))
                            begin
                                out_item_next.read_value = sample_reg[i];
                            end
                        end
                    end
                end

                default:
                begin
                    out_item_next = '0;
                end
            endcase

            out_item_next.mux_channel = waiting_next ? scan_ptr_next : '0;
            out_valid_next            = 1'b1;
        end

        // Configuration writes must arrive only while idle, unchecked by the block.
        // Any write to the enable register drops a pending conversion.
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCAN_ENABLE:
                begin
                    scan_enable_next = cfg_data[0];
                    waiting_next     = 1'b0;
                end
                CFG_CHANNEL_MASK:
                begin
                    chan_mask_next = cfg_data;
                end
                default:
                begin
                    chan_mask_next = chan_mask_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            scan_enable_reg <= 1'b0;
            chan_mask_reg   <= '0;
            waiting_reg     <= 1'b0;
            scan_ptr_reg    <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                sample_reg[i] <= '0;
            end
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            scan_enable_reg <= scan_enable_next;
            chan_mask_reg   <= chan_mask_next;
            waiting_reg     <= waiting_next;
            scan_ptr_reg    <= scan_ptr_next;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                sample_reg[i] <= sample_next[i];
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

`ifndef SYNTH
    // A conversion is only ever pending on an existing channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        waiting_reg |-> ({1'b0, scan_ptr_reg} < (PTR_W + 1)'(NUM_CHANNELS)))
        else $error("pending conversion on a channel that does not exist");

    // With the scan off nothing can be pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        !scan_enable_reg |-> !waiting_reg)
        else $error("conversion pending while scan is disabled");

    // A started conversion is never on channel zero and is reported as pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.start_conversion) |->
        (out_item_reg.mux_channel != '0 && !out_item_reg.read_ok))
        else $error("conversion start result is inconsistent");

    // A failed read reports a zero sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_item_reg.read_ok) |-> (out_item_reg.read_value == '0))
        else $error("read value not zero on a failed read");

    // A stage that advances always leaves a valid result behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed request produced no result");
`endif

endmodule
